FILE: hdl/sfs_pkg.sv
package sfs_pkg;

   localparam int MAX_FILES = 32;
   localparam int IDX_W     = $clog2(MAX_FILES);
   localparam int CNT_W     = IDX_W + 1;

   // command codes
   localparam logic [3:0] F_DEFINE  = 4'd0;
   localparam logic [3:0] F_RESET   = 4'd1;
   localparam logic [3:0] F_SELECT  = 4'd2;
   localparam logic [3:0] F_GETRESP = 4'd3;
   localparam logic [3:0] F_STATUS  = 4'd4;
   localparam logic [3:0] F_RDBIN   = 4'd5;
   localparam logic [3:0] F_UPBIN   = 4'd6;
   localparam logic [3:0] F_RDREC   = 4'd7;
   localparam logic [3:0] F_UPREC   = 4'd8;

   // file kinds
   localparam logic [2:0] K_MF  = 3'd0;
   localparam logic [2:0] K_DF  = 3'd1;
   localparam logic [2:0] K_TEF = 3'd2;
   localparam logic [2:0] K_LEF = 3'd3;
   localparam logic [2:0] K_CEF = 3'd4;

   // record pointer modes
   localparam logic [1:0] MODE_NEXT = 2'd0;
   localparam logic [1:0] MODE_PREV = 2'd1;
   localparam logic [1:0] MODE_ABS  = 2'd2;
   localparam logic [1:0] MODE_BAD  = 2'd3;

   // status codes
   localparam logic [2:0] S_OK       = 3'd0;
   localparam logic [2:0] S_BADPARAM = 3'd1;
   localparam logic [2:0] S_NOEF     = 3'd2;
   localparam logic [2:0] S_HINT     = 3'd3;
   localparam logic [2:0] S_BADLEN   = 3'd4;
   localparam logic [2:0] S_NOTFOUND = 3'd5;

   // register indexes
   localparam logic CSR_FILE_COUNT = 1'b0;
   localparam logic CSR_MF_ID      = 1'b1;

   localparam logic [8:0] REC_NONE      = 9'h1FF;
   localparam logic [4:0] DIR_META_SIZE = 5'd23;
   localparam logic [4:0] EF_META_SIZE  = 5'd15;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_SCAN, ST_COUNT, ST_META, ST_STREAM, ST_MUL, ST_CHECK, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {PH_ROOT, PH_CUR, PH_MF} phase_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] parent;
      logic [2:0]  kind;
      logic [15:0] size;
      logic [7:0]  rec_len;
      logic [15:0] base;
   } entry_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  detail;
      logic [7:0]  data_byte;
      logic        byte_valid;
      logic        last;
      logic [15:0] mem_address;
      logic [15:0] span_length;
      logic [4:0]  meta_len;
   } rsp_type;

   function automatic logic is_dir(input logic [2:0] k);
      return (k == K_MF) || (k == K_DF);
   endfunction

   function automatic logic is_rec(input logic [2:0] k);
      return (k == K_LEF) || (k == K_CEF);
   endfunction

   function automatic rsp_type make_status(input logic [2:0] st, input logic [7:0] det);
      rsp_type r;
      r        = '0;
      r.status = st;
      r.detail = det;
      r.last   = 1'b1;
      return r;
   endfunction

   function automatic logic [7:0] meta_byte(input logic [4:0] idx, input entry_type e,
                                            input logic [7:0] cdir, input logic [7:0] cef);
      logic [7:0] b;
      b = 8'h00;
      if (is_dir(e.kind)) begin
         case (idx)
            5'd2:  b = 8'h20;
            5'd4:  b = e.id[15:8];
            5'd5:  b = e.id[7:0];
            5'd6:  b = (e.kind == K_MF) ? 8'h01 : 8'h02;
            5'd12: b = 8'd10;
            5'd13: b = 8'h9B;
            5'd14: b = cdir;
            5'd15: b = cef;
            5'd16: b = 8'd4;
            5'd18: b = 8'h83;
            5'd19: b = 8'h8A;
            5'd20: b = 8'h83;
            5'd21: b = 8'h8A;
            default: b = 8'h00;
         endcase
      end else begin
         case (idx)
            5'd2:  b = e.size[15:8];
            5'd3:  b = e.size[7:0];
            5'd4:  b = e.id[15:8];
            5'd5:  b = e.id[7:0];
            5'd6:  b = 8'h04;
            5'd11: b = 8'h01;
            5'd12: b = 8'd2;
            5'd13: b = (e.kind == K_LEF) ? 8'h01 : ((e.kind == K_CEF) ? 8'h03 : 8'h00);
            5'd14: b = e.rec_len;
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

FILE: hdl/sfs_table_ram.sv
module sfs_table_ram
   import sfs_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_FILES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sim_file_select_and_record_access_unit.sv
// SIM file-system front end.
// Request channel (req_*): one command per request, accepted when req_valid is high and
// req_stall low. req_stall stays high from acceptance until the command's last result
// has been loaded into the output register.
// Result channel (rsp_*): one result per cycle from a single output register; rsp_last
// marks the final result of a command. Metadata streams give one result per byte.
// Config channel (csr_*): always ready; index 0 file count, index 1 master file id.
// Sequencing after acceptance: define entry and unknown codes load the result directly;
// binary access first reads the selected entry; record access reads it, multiplies and
// checks; select and card reset walk the file table in the entry RAM, one entry a
// cycle, again on a fallback search for a DF under the master file; status and get
// response read one entry, walk the table to count children for directories,
// then stream up to 23 bytes, one a cycle unless stalled. RAM reads are registered.
// A stalled receiver holds the output register; the sequencer waits before loading
// the next result.
// Reset clears directory and selection to entry 0, the record pointer to none, file
// count to 0 and the master file id to 3F00h. Table entries are undefined until
// defined.
module sim_file_select_and_record_access_unit
   import sfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_func,
   input  logic [15:0] req_file_id,
   input  logic [15:0] req_parent_ref,
   input  logic [2:0]  req_file_kind,
   input  logic [15:0] req_file_size,
   input  logic [7:0]  req_record_length,
   input  logic [15:0] req_base_address,
   input  logic [4:0]  req_entry_index,
   input  logic [7:0]  req_record_number,
   input  logic [1:0]  req_record_mode,
   input  logic [15:0] req_offset,
   input  logic [15:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_status_detail,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [15:0] rsp_mem_address,
   output logic [15:0] rsp_span_length,
   output logic [4:0]  rsp_meta_len,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // control state
   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] dir_ff, dir_in;
   logic [IDX_W-1:0] sel_ff, sel_in;
   logic [8:0]       rp_ff, rp_in;
   logic [5:0]       fc_ff;
   logic [15:0]      mfid_ff;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic             oval_ff, oval_in;

   // command and work registers
   logic [3:0]       func_ff;
   logic [15:0]      fid_ff;
   logic [7:0]       rec_ff;
   logic [1:0]       mode_ff;
   logic [15:0]      off_ff;
   logic [15:0]      len_ff;
   logic [15:0]      key_id_ff, key_id_in;
   logic [15:0]      key_par_ff, key_par_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   entry_type        ent_ff, ent_in;
   logic [7:0]       cdir_ff, cdir_in;
   logic [7:0]       cef_ff, cef_in;
   logic [9:0]       pc_ff, pc_in;
   logic             fail_ff, fail_in;
   logic [17:0]      mul_ff, mul_in;
   logic [4:0]       bidx_ff, bidx_in;
   logic [4:0]       blast_ff, blast_in;
   rsp_type          res_ff, res_in;
   rsp_type          out_ff, out_in;

   // entry RAM
   logic             ram_we;
   logic [IDX_W-1:0] ram_raddr;
   entry_type        ram_wdata;
   entry_type        rd;

   logic [CNT_W-1:0] live_n;
   logic             can_emit;
   logic             scan_end;
   logic [16:0]      bin_end;
   logic [17:0]      rec_off;
   logic [4:0]       meta_size;
   logic             accept;

   sfs_table_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_entry_index[IDX_W-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (rd)
   );

   assign ram_wdata = '{id: req_file_id, parent: req_parent_ref, kind: req_file_kind,
                        size: req_file_size, rec_len: req_record_length,
                        base: req_base_address};

   assign live_n    = (fc_ff > 6'(MAX_FILES)) ? CNT_W'(MAX_FILES) : CNT_W'(fc_ff);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign can_emit  = !oval_ff || !rsp_stall;
   assign scan_end  = !pend_ff && (scan_ff >= live_n);
   assign bin_end   = {1'b0, off_ff} + {1'b0, len_ff};
   assign rec_off   = mul_ff - {10'd0, ent_ff.rec_len};
   assign meta_size = is_dir(ent_ff.kind) ? DIR_META_SIZE : EF_META_SIZE;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      dir_in     = dir_ff;
      sel_in     = sel_ff;
      rp_in      = rp_ff;
      scan_in    = scan_ff;
      pend_in    = 1'b0;
      pidx_in    = pidx_ff;
      key_id_in  = key_id_ff;
      key_par_in = key_par_ff;
      ent_in     = ent_ff;
      cdir_in    = cdir_ff;
      cef_in     = cef_ff;
      pc_in      = pc_ff;
      fail_in    = fail_ff;
      mul_in     = mul_ff;
      bidx_in    = bidx_ff;
      blast_in   = blast_ff;
      res_in     = res_ff;
      oval_in    = oval_ff && rsp_stall;
      out_in     = out_ff;
      ram_we     = 1'b0;
      ram_raddr  = sel_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_func == F_SELECT || req_func == F_STATUS) begin
               ram_raddr = dir_ff;
            end
            if (accept) begin
               scan_in = '0;
               case (req_func)
                  F_DEFINE: begin
                     ram_we   = 1'b1;
                     res_in   = make_status(S_OK, 8'd0);
                     state_in = ST_EMIT;
                  end
                  F_RESET: begin
                     key_id_in  = mfid_ff;
                     key_par_in = 16'd0;
                     phase_in   = PH_ROOT;
                     state_in   = ST_SCAN;
                  end
                  F_SELECT: begin
                     if (req_file_id == mfid_ff) begin
                        key_id_in  = req_file_id;
                        key_par_in = 16'd0;
                        phase_in   = PH_ROOT;
                        state_in   = ST_SCAN;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  F_GETRESP, F_STATUS, F_RDBIN, F_UPBIN, F_RDREC, F_UPREC: begin
                     state_in = ST_FETCH;
                  end
                  default: begin
                     res_in   = make_status(S_BADPARAM, 8'd0);
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end

         ST_FETCH: begin
            ent_in = rd;
            case (func_ff)
               F_SELECT: begin
                  key_id_in  = fid_ff;
                  key_par_in = rd.id;
                  phase_in   = PH_CUR;
                  scan_in    = '0;
                  state_in   = ST_SCAN;
               end
               F_GETRESP, F_STATUS: begin
                  cdir_in  = 8'd0;
                  cef_in   = 8'd0;
                  scan_in  = '0;
                  state_in = is_dir(rd.kind) ? ST_COUNT : ST_META;
               end
               F_RDBIN, F_UPBIN: begin
                  if (rd.kind != K_TEF || bin_end > {1'b0, rd.size}) begin
                     res_in = make_status(S_BADPARAM, 8'd0);
                  end else begin
                     res_in             = make_status(S_OK, 8'd0);
                     res_in.mem_address = rd.base + off_ff;
                     res_in.span_length = len_ff;
                  end
                  state_in = ST_EMIT;
               end
               F_RDREC, F_UPREC: begin
                  // candidate pointer; range check follows after the multiply
                  fail_in = !is_rec(rd.kind) || (rd.rec_len == 8'd0);
                  pc_in   = {1'b0, rp_ff};
                  case (mode_ff)
                     MODE_NEXT: begin
                        pc_in = (rp_ff == REC_NONE) ? 10'd0 : ({1'b0, rp_ff} + 10'd1);
                     end
                     MODE_PREV: begin
                        if (rp_ff == REC_NONE || rp_ff == 9'd0) begin
                           fail_in = 1'b1;
                        end
                        pc_in = {1'b0, rp_ff} - 10'd1;
                     end
                     MODE_ABS: begin
                        if (rec_ff != 8'd0) begin
                           pc_in = {2'b0, rec_ff} - 10'd1;
                        end else if (rp_ff == REC_NONE) begin
                           fail_in = 1'b1;
                        end
                     end
                     default: begin
                        fail_in = 1'b1;
                     end
                  endcase
                  state_in = ST_MUL;
               end
               default: begin
                  res_in   = make_status(S_BADPARAM, 8'd0);
                  state_in = ST_EMIT;
               end
            endcase
         end

         ST_SCAN: begin
            ram_raddr = scan_ff[IDX_W-1:0];
            if (scan_ff < live_n) begin
               pend_in = 1'b1;
               pidx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
            end
            if (pend_ff && rd.id == key_id_ff && rd.parent == key_par_ff) begin
               pend_in  = 1'b0;
               state_in = ST_EMIT;
               if (func_ff == F_RESET) begin
                  rp_in = REC_NONE;
                  if (rd.kind == K_MF) begin
                     dir_in = pidx_ff;
                     sel_in = pidx_ff;
                     res_in = make_status(S_OK, 8'd0);
                  end else begin
                     dir_in = '0;
                     sel_in = '0;
                     res_in = make_status(S_NOTFOUND, 8'd0);
                  end
               end else if (phase_ff == PH_MF && rd.kind != K_DF) begin
                  res_in = make_status(S_NOTFOUND, 8'd0);
               end else begin
                  if (is_dir(rd.kind)) begin
                     dir_in = pidx_ff;
                  end
                  sel_in          = pidx_ff;
                  rp_in           = REC_NONE;
                  res_in          = make_status(S_OK, 8'd0);
                  res_in.meta_len = is_dir(rd.kind) ? DIR_META_SIZE : EF_META_SIZE;
               end
            end else if (scan_end) begin
               if (func_ff == F_RESET) begin
                  rp_in    = REC_NONE;
                  dir_in   = '0;
                  sel_in   = '0;
                  res_in   = make_status(S_NOTFOUND, 8'd0);
                  state_in = ST_EMIT;
               end else if (phase_ff == PH_CUR) begin
                  // fall back to a DF directly under the MF
                  key_par_in = mfid_ff;
                  phase_in   = PH_MF;
                  scan_in    = '0;
                  pend_in    = 1'b0;
               end else begin
                  res_in   = make_status(S_NOTFOUND, 8'd0);
                  state_in = ST_EMIT;
               end
            end
         end

         ST_COUNT: begin
            ram_raddr = scan_ff[IDX_W-1:0];
            if (scan_ff < live_n) begin
               pend_in = 1'b1;
               scan_in = scan_ff + CNT_W'(1);
            end
            if (pend_ff && rd.parent == ent_ff.id) begin
               if (is_dir(rd.kind)) begin
                  cdir_in = cdir_ff + 8'd1;
               end else begin
                  cef_in = cef_ff + 8'd1;
               end
            end
            if (scan_end) begin
               state_in = ST_META;
            end
         end

         ST_META: begin
            if (len_ff == 16'd0 || len_ff > {11'd0, meta_size}) begin
               res_in   = make_status(S_HINT, {3'd0, meta_size});
               state_in = ST_EMIT;
            end else begin
               bidx_in  = 5'd0;
               blast_in = len_ff[4:0] - 5'd1;
               state_in = ST_STREAM;
            end
         end

         ST_STREAM: begin
            if (can_emit) begin
               oval_in            = 1'b1;
               out_in             = '0;
               out_in.data_byte   = meta_byte(bidx_ff, ent_ff, cdir_ff, cef_ff);
               out_in.byte_valid  = 1'b1;
               out_in.last        = (bidx_ff == blast_ff);
               bidx_in            = bidx_ff + 5'd1;
               if (bidx_ff == blast_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_MUL: begin
            // (p + 1) * record length; p * length follows by one subtract
            mul_in   = ({8'd0, pc_ff} + 18'd1) * {10'd0, ent_ff.rec_len};
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            state_in = ST_EMIT;
            if (fail_ff || pc_ff >= {1'b0, REC_NONE} || mul_ff > {2'd0, ent_ff.size}) begin
               res_in = make_status(S_NOEF, 8'd0);
            end else begin
               rp_in = pc_ff[8:0];
               if (len_ff != {8'd0, ent_ff.rec_len}) begin
                  res_in = (func_ff == F_RDREC) ? make_status(S_HINT, ent_ff.rec_len)
                                                : make_status(S_BADLEN, 8'd0);
               end else begin
                  res_in             = make_status(S_OK, 8'd0);
                  res_in.mem_address = ent_ff.base + rec_off[15:0];
                  res_in.span_length = len_ff;
               end
            end
         end

         ST_EMIT: begin
            if (can_emit) begin
               oval_in  = 1'b1;
               out_in   = res_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_ROOT;
         dir_ff   <= '0;
         sel_ff   <= '0;
         rp_ff    <= REC_NONE;
         fc_ff    <= 6'd0;
         mfid_ff  <= 16'h3F00;
         scan_ff  <= '0;
         pend_ff  <= 1'b0;
         oval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         dir_ff   <= dir_in;
         sel_ff   <= sel_in;
         rp_ff    <= rp_in;
         scan_ff  <= scan_in;
         pend_ff  <= pend_in;
         oval_ff  <= oval_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FILE_COUNT) begin
               fc_ff <= csr_wdata[5:0];
            end else if (csr_index == CSR_MF_ID) begin
               mfid_ff <= csr_wdata;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         fid_ff  <= req_file_id;
         rec_ff  <= req_record_number;
         mode_ff <= req_record_mode;
         off_ff  <= req_offset;
         len_ff  <= req_length;
      end
      key_id_ff  <= key_id_in;
      key_par_ff <= key_par_in;
      pidx_ff    <= pidx_in;
      ent_ff     <= ent_in;
      cdir_ff    <= cdir_in;
      cef_ff     <= cef_in;
      pc_ff      <= pc_in;
      fail_ff    <= fail_in;
      mul_ff     <= mul_in;
      bidx_ff    <= bidx_in;
      blast_ff   <= blast_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = oval_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_status_detail = out_ff.detail;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_byte_valid    = out_ff.byte_valid;
   assign rsp_last          = out_ff.last;
   assign rsp_mem_address   = out_ff.mem_address;
   assign rsp_span_length   = out_ff.span_length;
   assign rsp_meta_len      = out_ff.meta_len;

endmodule

FILE: test/tb_top.sv
`default_nettype none

module tb_top;
   import sfs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // "no current record" marker and the largest response
   localparam int unsigned NO_RECORD = 511;
   localparam int unsigned RESP_MAX  = 256;
   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      logic [3:0]  func;
      logic [15:0] file_id;
      logic [15:0] parent_ref;
      logic [2:0]  file_kind;
      logic [15:0] file_size;
      logic [7:0]  record_length;
      logic [15:0] base_address;
      logic [4:0]  entry_index;
      logic [7:0]  record_number;
      logic [1:0]  record_mode;
      logic [15:0] offset;
      logic [15:0] length;
   } sim_cmd_type;

   // Predicts the responses of the file system and holds the ones still due.
   class file_system_scoreboard;
      logic [15:0] ids[MAX_FILES];
      logic [15:0] parents[MAX_FILES];
      logic [2:0]  kinds[MAX_FILES];
      logic [15:0] sizes[MAX_FILES];
      logic [7:0]  rec_lens[MAX_FILES];
      logic [15:0] bases[MAX_FILES];
      int unsigned dir_idx = 0;
      int unsigned sel_idx = 0;
      int unsigned rec_ptr = NO_RECORD;
      int unsigned file_count = 0;
      logic [15:0] mf_id = 16'h3F00;
      rsp_type     due[$];
      int          errors = 0;

      function void write_reg(logic idx, logic [15:0] wdata);
         if (idx == CSR_FILE_COUNT) file_count = wdata[5:0];
         else mf_id = wdata;
      endfunction

      function int unsigned live();
         return (file_count < MAX_FILES) ? file_count : MAX_FILES;
      endfunction

      function bit dir_kind(logic [2:0] k);
         return (k == K_MF) || (k == K_DF);
      endfunction

      function int lookup(logic [15:0] id, logic [15:0] parent);
         for (int i = 0; i < live(); i++)
            if (ids[i] == id && parents[i] == parent) return i;
         return -1;
      endfunction

      function logic [7:0] children(logic [15:0] parent, bit dirs);
         int unsigned c;
         c = 0;
         for (int i = 0; i < live(); i++)
            if (parents[i] == parent && dir_kind(kinds[i]) == dirs) c++;
         return c[7:0];
      endfunction

      function void push(logic [2:0] st, logic [7:0] det, logic [7:0] data, logic bv,
                         logic lst, logic [15:0] addr, logic [15:0] span, logic [4:0] rs);
         rsp_type r;
         r.status = st; r.detail = det; r.data_byte = data; r.byte_valid = bv;
         r.last = lst; r.mem_address = addr; r.span_length = span; r.meta_len = rs;
         due.push_back(r);
      endfunction

      function void push_status(logic [2:0] st, logic [7:0] det);
         push(st, det, 8'h00, 1'b0, 1'b1, 16'h0, 16'h0, 5'd0);
      endfunction

      // Build the file descriptor bytes of entry e and stream them, or hint the size.
      function void stream_descriptor(int unsigned e, logic [15:0] req);
         logic [7:0]  m[23];
         int unsigned size, want;
         logic [2:0]  k;
         k = kinds[e];
         foreach (m[i]) m[i] = 8'h00;
         m[4] = ids[e][15:8];
         m[5] = ids[e][7:0];
         m[6] = (k == K_MF) ? 8'h01 : ((k == K_DF) ? 8'h02 : 8'h04);
         if (dir_kind(k)) begin
            m[2] = 8'h20; m[12] = 8'd10; m[13] = 8'h9B;
            m[14] = children(ids[e], 1'b1);
            m[15] = children(ids[e], 1'b0);
            m[16] = 8'd4; m[18] = 8'h83; m[19] = 8'h8A; m[20] = 8'h83; m[21] = 8'h8A;
            size = DIR_META_SIZE;
         end else begin
            m[2] = sizes[e][15:8]; m[3] = sizes[e][7:0];
            m[11] = 8'h01; m[12] = 8'd2;
            m[13] = (k == K_LEF) ? 8'h01 : ((k == K_CEF) ? 8'h03 : 8'h00);
            m[14] = rec_lens[e];
            size = EF_META_SIZE;
         end
         want = (req != 0) ? req : RESP_MAX;
         if (want > size) begin
            push_status(S_HINT, size[7:0]);
            return;
         end
         for (int i = 0; i < want; i++)
            push(S_OK, 8'h00, m[i], 1'b1, (i + 1 == want), 16'h0, 16'h0, 5'd0);
      endfunction

      function bit move_pointer(int unsigned e, int unsigned rec, logic [1:0] mode);
         int unsigned rl, cnt, p;
         rl = rec_lens[e];
         p  = rec_ptr;
         if (rl == 0) return 0;
         cnt = sizes[e] / rl;
         case (mode)
            MODE_NEXT: p = (p == NO_RECORD) ? 0 : p + 1;
            MODE_PREV: begin
               if (p == NO_RECORD || p == 0) return 0;
               p--;
            end
            MODE_ABS: begin
               if (rec != 0) p = rec - 1;
               else if (p == NO_RECORD) return 0;
            end
            default: return 0;
         endcase
         if (p >= cnt || p >= NO_RECORD) return 0;
         rec_ptr = p;
         return 1;
      endfunction

      // Work out every response an accepted request causes.
      function void note(sim_cmd_type c);
         int          f;
         int unsigned sel, span;
         logic [15:0] addr;
         sel = sel_idx;
         case (c.func)
            F_DEFINE: begin
               ids[c.entry_index]      = c.file_id;
               parents[c.entry_index]  = c.parent_ref;
               kinds[c.entry_index]    = c.file_kind;
               sizes[c.entry_index]    = c.file_size;
               rec_lens[c.entry_index] = c.record_length;
               bases[c.entry_index]    = c.base_address;
               push_status(S_OK, 8'h00);
            end
            F_RESET: begin
               f = lookup(mf_id, 16'h0000);
               rec_ptr = NO_RECORD;
               if (f >= 0 && kinds[f] == K_MF) begin
                  dir_idx = f; sel_idx = f;
                  push_status(S_OK, 8'h00);
               end else begin
                  dir_idx = 0; sel_idx = 0;
                  push_status(S_NOTFOUND, 8'h00);
               end
            end
            F_SELECT: begin
               if (c.file_id == mf_id) f = lookup(c.file_id, 16'h0000);
               else begin
                  f = lookup(c.file_id, ids[dir_idx]);
                  if (f < 0) begin
                     f = lookup(c.file_id, mf_id);
                     if (f >= 0 && kinds[f] != K_DF) f = -1;
                  end
               end
               if (f < 0) push_status(S_NOTFOUND, 8'h00);
               else begin
                  if (dir_kind(kinds[f])) dir_idx = f;
                  sel_idx = f;
                  rec_ptr = NO_RECORD;
                  push(S_OK, 8'h00, 8'h00, 1'b0, 1'b1, 16'h0, 16'h0,
                       dir_kind(kinds[f]) ? DIR_META_SIZE : EF_META_SIZE);
               end
            end
            F_GETRESP: stream_descriptor(sel, c.length);
            F_STATUS:  stream_descriptor(dir_idx, c.length);
            F_RDBIN, F_UPBIN: begin
               span = int'(c.offset) + int'(c.length);
               if (kinds[sel] != K_TEF || span > sizes[sel]) push_status(S_BADPARAM, 8'h00);
               else begin
                  addr = bases[sel] + c.offset;
                  push(S_OK, 8'h00, 8'h00, 1'b0, 1'b1, addr, c.length, 5'd0);
               end
            end
            F_RDREC, F_UPREC: begin
               if (!(kinds[sel] == K_LEF || kinds[sel] == K_CEF) ||
                   !move_pointer(sel, c.record_number, c.record_mode))
                  push_status(S_NOEF, 8'h00);
               else if (c.length != rec_lens[sel]) begin
                  if (c.func == F_RDREC) push_status(S_HINT, rec_lens[sel]);
                  else push_status(S_BADLEN, 8'h00);
               end else begin
                  addr = 16'(bases[sel] + rec_ptr * rec_lens[sel]);
                  push(S_OK, 8'h00, 8'h00, 1'b0, 1'b1, addr, c.length, 5'd0);
               end
            end
            default: push_status(S_BADPARAM, 8'h00);
         endcase
      endfunction

      function void field(string name, int unsigned exp_v, int unsigned act_v);
         if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check(rsp_type got);
         rsp_type e;
         if (due.size() == 0) begin
            $error("response with nothing due: status %0d", got.status);
            errors++;
            return;
         end
         e = due.pop_front();
         field("status", e.status, got.status);
         field("status_detail", e.detail, got.detail);
         field("data_byte", e.data_byte, got.data_byte);
         field("byte_valid", e.byte_valid, got.byte_valid);
         field("last", e.last, got.last);
         field("mem_address", e.mem_address, got.mem_address);
         field("span_length", e.span_length, got.span_length);
         field("meta_len", e.meta_len, got.meta_len);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sim_cmd_type cmd;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_status_detail;
   logic [7:0]  rsp_data_byte;
   logic        rsp_byte_valid;
   logic        rsp_last;
   logic [15:0] rsp_mem_address;
   logic [15:0] rsp_span_length;
   logic [4:0]  rsp_meta_len;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = 16'h0;

   file_system_scoreboard sb = new();
   int burst_left = 0;
   int idle_cycles = 0;
   logic [15:0] mf_now = 16'h3F00;

   sim_file_select_and_record_access_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(cmd.func), .req_file_id(cmd.file_id), .req_parent_ref(cmd.parent_ref),
      .req_file_kind(cmd.file_kind), .req_file_size(cmd.file_size),
      .req_record_length(cmd.record_length), .req_base_address(cmd.base_address),
      .req_entry_index(cmd.entry_index), .req_record_number(cmd.record_number),
      .req_record_mode(cmd.record_mode), .req_offset(cmd.offset), .req_length(cmd.length),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_status_detail(rsp_status_detail), .rsp_data_byte(rsp_data_byte),
      .rsp_byte_valid(rsp_byte_valid), .rsp_last(rsp_last),
      .rsp_mem_address(rsp_mem_address), .rsp_span_length(rsp_span_length),
      .rsp_meta_len(rsp_meta_len),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sample both channels and the register port at the rising edge; feed the scoreboard.
   always @(posedge clock) begin
      rsp_type got;
      bit      moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_wdata);
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            sb.note(cmd);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status; got.detail = rsp_status_detail;
            got.data_byte = rsp_data_byte; got.byte_valid = rsp_byte_valid;
            got.last = rsp_last; got.mem_address = rsp_mem_address;
            got.span_length = rsp_span_length; got.meta_len = rsp_meta_len;
            sb.check(got);
            moved = 1'b1;
         end
      end
      // watchdog: too long without any handshake means the block is hung
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver stall: switch between no stall, light random stall and heavy stall.
   always @(negedge clock) begin
      static int mode_left = 0;
      static int stall_mode = 0;
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Drive one request; hold it until accepted, then advance in bursts with random gaps.
   task automatic send(sim_cmd_type c);
      int gap;
      if (burst_left <= 0) burst_left = $urandom_range(1, 12);
      req_valid <= 1'b1;
      cmd       <= c;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Drop the request valid and hold until every due response has arrived.
   task automatic drain();
      @(negedge clock);
      req_valid  <= 1'b0;
      burst_left <= 0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] wdata);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic sim_cmd_type noise();
      sim_cmd_type c;
      c.func = $urandom; c.file_id = $urandom; c.parent_ref = $urandom;
      c.file_kind = $urandom; c.file_size = $urandom; c.record_length = $urandom;
      c.base_address = $urandom; c.entry_index = $urandom; c.record_number = $urandom;
      c.record_mode = $urandom; c.offset = $urandom; c.length = $urandom;
      return c;
   endfunction

   function automatic logic [15:0] dir_id_pick();
      case ($urandom_range(0, 3))
         0:       return mf_now;
         1:       return 16'h7F10;
         2:       return 16'h7F20;
         default: return 16'h7F21;
      endcase
   endfunction

   function automatic sim_cmd_type define_cmd(logic [4:0] slot, logic [2:0] kind,
                                             logic [15:0] id, logic [15:0] parent);
      sim_cmd_type c;
      c = noise();
      c.func = F_DEFINE; c.entry_index = slot; c.file_kind = kind;
      c.file_id = id; c.parent_ref = parent;
      if (kind != K_MF && kind != K_DF) begin
         c.file_size     = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600);
         c.record_length = $urandom_range(0, 5) == 0 ? 8'd0 : $urandom_range(1, 40);
      end
      return c;
   endfunction

   // Fill every slot so no later command reads an entry that was never defined:
   // MF, two DFs under it and one under the first DF, then mostly elementary files.
   task automatic build_table();
      logic [2:0] k;
      send(define_cmd(5'd0, K_MF, mf_now, 16'h0000));
      send(define_cmd(5'd1, K_DF, 16'h7F10, mf_now));
      send(define_cmd(5'd2, K_DF, 16'h7F20, mf_now));
      send(define_cmd(5'd3, K_DF, 16'h7F21, 16'h7F10));
      for (int s = 4; s < MAX_FILES; s++) begin
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(2, 4);
         send(define_cmd(s, k, 16'h6F00 + s[15:0], dir_id_pick()));
      end
   endtask

   function automatic sim_cmd_type cmd_of(logic [3:0] f);
      sim_cmd_type c;
      c = noise();
      c.func = f;
      return c;
   endfunction

   // Mostly well-formed commands aimed at the files present, some noise.
   function automatic sim_cmd_type random_cmd();
      sim_cmd_type c;
      int unsigned sel, pick;
      sel  = sb.sel_idx;
      pick = $urandom_range(0, 99);
      c    = noise();
      if (pick < 6) begin
         c = define_cmd($urandom_range(4, 31), $urandom_range(2, 4),
                        16'h6F00 + $urandom_range(0, 40), dir_id_pick());
      end else if (pick < 28) begin
         c.func    = F_SELECT;
         c.file_id = ($urandom_range(0, 2) == 0) ? dir_id_pick() : sb.ids[$urandom_range(0, 31)];
      end else if (pick < 38) begin
         c.func   = F_GETRESP;
         c.length = ($urandom_range(0, 1)) ? 16'd0 : $urandom_range(1, 25);
      end else if (pick < 44) begin
         c.func   = F_STATUS;
         c.length = ($urandom_range(0, 1)) ? 16'd0 : $urandom_range(1, 25);
      end else if (pick < 58) begin
         c.func   = $urandom_range(0, 1) ? F_RDBIN : F_UPBIN;
         c.offset = $urandom_range(0, int'(sb.sizes[sel]) + 4);
         c.length = $urandom_range(0, 64);
      end else if (pick < 84) begin
         c.func          = $urandom_range(0, 1) ? F_RDREC : F_UPREC;
         c.record_mode   = ($urandom_range(0, 9) == 0) ? MODE_BAD : $urandom_range(0, 2);
         c.record_number = $urandom_range(0, 12);
         c.length        = ($urandom_range(0, 3) != 0) ? {8'h00, sb.rec_lens[sel]}
                                                      : $urandom_range(0, 40);
      end else if (pick < 89) begin
         c.func = F_RESET;
      end else if (pick < 92) begin
         c.func = $urandom_range(9, 15);
      end else if (c.func == F_DEFINE) begin
         c.func = F_STATUS;   // keep the table sane; noise defines come from above
      end
      return c;
   endfunction

   task automatic run_random(int count);
      repeat (count) send(random_cmd());
   endtask

   task automatic directed();
      sim_cmd_type c;
      send(cmd_of(F_RESET));
      c = cmd_of(F_STATUS);  c.length = 16'd0;  send(c);
      c = cmd_of(F_GETRESP); c.length = 16'd24; send(c);    // over the descriptor size
      c = cmd_of(F_SELECT);  c.file_id = 16'h7F10; send(c);
      c = cmd_of(F_GETRESP); c.length = 16'd23; send(c);
      c = cmd_of(F_SELECT);  c.file_id = 16'hFFFF; send(c); // not present
      // elementary file with extreme contents in the top slot
      c = define_cmd(5'd31, K_TEF, 16'h6F1F, 16'h7F10);
      c.file_size = 16'hFFFF; c.base_address = 16'hFFFF; c.record_length = 8'hFF;
      send(c);
      c = cmd_of(F_SELECT);  c.file_id = 16'h6F1F; send(c);
      c = cmd_of(F_GETRESP); c.length = 16'd1; send(c);
      c = cmd_of(F_RDBIN); c.offset = 16'h0001; c.length = 16'hFFFE; send(c); // wraps
      c = cmd_of(F_UPBIN); c.offset = 16'hFFFF; c.length = 16'hFFFF; send(c); // too far
      c = cmd_of(F_RDREC); send(c);                                           // not records
      // linear fixed file with five records of 10 bytes
      c = define_cmd(5'd30, K_LEF, 16'h6F1E, 16'h7F10);
      c.file_size = 16'd50; c.record_length = 8'd10; c.base_address = 16'hFFF0;
      send(c);
      c = cmd_of(F_SELECT); c.file_id = 16'h6F1E; send(c);
      c = cmd_of(F_RDREC); c.record_mode = MODE_PREV; c.length = 16'd10; send(c);
      c = cmd_of(F_RDREC); c.record_mode = MODE_ABS; c.record_number = 8'd0;
      c.length = 16'd10; send(c);                                  // no current record
      c = cmd_of(F_RDREC); c.record_mode = MODE_NEXT; c.length = 16'd10; send(c);
      c = cmd_of(F_UPREC); c.record_mode = MODE_ABS; c.record_number = 8'd5;
      c.length = 16'd10; send(c);
      c = cmd_of(F_RDREC); c.record_mode = MODE_ABS; c.record_number = 8'hFF;
      c.length = 16'd10; send(c);                                  // past the end
      c = cmd_of(F_RDREC); c.record_mode = MODE_PREV; c.length = 16'd3; send(c);
      c = cmd_of(F_UPREC); c.record_mode = MODE_NEXT; c.length = 16'd3; send(c);
      c = cmd_of(F_UPREC); c.record_mode = MODE_BAD; c.length = 16'd10; send(c);
      send(cmd_of(4'd9));
      send(cmd_of(4'd15));
      c = define_cmd(5'd29, 3'd7, 16'h6F1D, mf_now); send(c);      // unknown kind
   endtask

   initial begin
      cmd = '{default: '0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_reg(CSR_FILE_COUNT, 16'd0);
      write_reg(CSR_MF_ID, mf_now);
      build_table();
      run_random(15);                  // file count 0: every search misses
      drain();
      write_reg(CSR_FILE_COUNT, 16'd32);
      directed();
      run_random(100);
      drain();
      write_reg(CSR_FILE_COUNT, 16'd20);
      run_random(80);
      drain();
      mf_now = 16'hFFFF;
      write_reg(CSR_MF_ID, mf_now);
      build_table();
      drain();
      write_reg(CSR_FILE_COUNT, 16'd63);
      run_random(100);
      drain();
      mf_now = 16'h0000;
      write_reg(CSR_MF_ID, mf_now);
      write_reg(CSR_FILE_COUNT, 16'd1);
      build_table();
      run_random(40);

      drain();
      if (sb.errors == 0 && sb.due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim_file_select_and_record_access_unit.f
hdl/sfs_pkg.sv
hdl/sfs_table_ram.sv
hdl/sim_file_select_and_record_access_unit.sv
test/tb_top.sv
